// ===== sv/bvp_pkg.sv =====
// Package for the MSB-first bit vector packer.
// Holds the sizes, operation and error codes, sequencer states and the
// structs passed between the store, the merge unit and the top level.
package bvp_pkg;

   localparam int CAP_BYTES = 4096;
   localparam int ADDR_W    = $clog2(CAP_BYTES);
   localparam int CAP_BITS  = CAP_BYTES * 8;
   localparam int FILL_W    = 16;
   localparam int BYTES_W   = 13;

   localparam logic [5:0] MAX_APPEND_BITS = 6'd32;

   localparam logic [2:0] OP_CLEAR       = 3'd0;
   localparam logic [2:0] OP_APPEND_BIT  = 3'd1;
   localparam logic [2:0] OP_APPEND_BITS = 3'd2;
   localparam logic [2:0] OP_READ_BIT    = 3'd3;
   localparam logic [2:0] OP_XOR_BYTE    = 3'd4;
   localparam logic [2:0] OP_READ_BYTE   = 3'd5;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_INDEX     = 3'd1;
   localparam logic [2:0] ERR_BIT_VALUE = 3'd2;
   localparam logic [2:0] ERR_BIT_COUNT = 3'd3;
   localparam logic [2:0] ERR_LENGTH    = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_READ_BIT,
      ST_READ_BYTE,
      ST_XOR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [2:0]  off;
      logic [5:0]  rem;
      logic [31:0] data;
      logic [7:0]  tail;
   } merge_in_type;

   typedef struct packed {
      logic [7:0]  wr_byte;
      logic [3:0]  take;
      logic [31:0] data;
   } merge_out_type;

endpackage

// ===== sv/bvp_store.sv =====
// Byte store of the packer: one write port and one registered read port.
// Depends on bvp_pkg for the capacity and the request struct.
module bvp_store (
   input  logic                clock,
   input  bvp_pkg::mem_req_type mem_req,
   output logic [7:0]          rd_data
);
   import bvp_pkg::*;

   logic [7:0] mem [CAP_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bvp_merge.sv =====
// Shared merge unit: places up to one byte's worth of left-aligned bits
// into the byte at the current fill offset. Depends on bvp_pkg.
module bvp_merge (
   input  bvp_pkg::merge_in_type  merge_in,
   output bvp_pkg::merge_out_type merge_out
);
   import bvp_pkg::*;

   logic [3:0] room;
   logic [3:0] take;
   logic [7:0] base;

   always_comb begin
      room = 4'd8 - {1'b0, merge_in.off};
      if (merge_in.rem < {2'b00, room}) begin
         take = merge_in.rem[3:0];
      end else begin
         take = room;
      end
      base = (merge_in.off == 3'd0) ? 8'd0 : merge_in.tail;
      merge_out.wr_byte = base | (merge_in.data[31:24] >> merge_in.off);
      merge_out.take    = take;
      merge_out.data    = merge_in.data << take;
   end

endmodule

// ===== sv/msb_first_bit_vector_packer_unit.sv =====
// MSB-first bit vector packer, top level.
// Uses bvp_pkg, bvp_store and bvp_merge.
//
// Each request word carries an opcode and its operands; each one gives
// exactly one response word with read data, an error code and the bit and
// byte counts after the operation. Both channels use valid and ready.
// The block takes one request at a time. Clear, unused opcodes and
// failed requests go from acceptance straight to the finish step, which
// loads the response register. Reads and byte XORs first pass their read
// or XOR state, which takes the registered store read and forms the
// result or writes the byte back. An append of n bits stays in the append
// state, the merge unit writing one byte of the store per cycle.
// A new request is accepted as soon as the sequencer is idle, even while
// the previous response still waits; a finished operation holds in its
// last step until the response register is free, so a stalled receiver
// holds back the next response but loses nothing.
// Synchronous reset empties the vector and drops any pending response;
// the store contents are not cleared, since only written bytes are read.
module msb_first_bit_vector_packer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_value,
   input  logic [5:0]  req_num_bits,
   input  logic [14:0] req_index,
   input  logic [15:0] req_other_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_error,
   output logic [15:0] rsp_bit_count,
   output logic [12:0] rsp_byte_count
);
   import bvp_pkg::*;

   state_type state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [7:0]         tail_ff, tail_in;
   logic [31:0]        data_ff, data_in;
   logic [5:0]         rem_ff, rem_in;
   logic [14:0]        idx_ff, idx_in;
   logic [7:0]         xor_ff, xor_in;
   logic [7:0]         res_data_ff, res_data_in;
   logic [2:0]         res_err_ff, res_err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic [2:0]         rsp_err_ff, rsp_err_in;
   logic [FILL_W-1:0]  rsp_bits_ff, rsp_bits_in;
   logic [BYTES_W-1:0] rsp_bytes_ff, rsp_bytes_in;

   logic [FILL_W:0]    fill_round;
   logic [BYTES_W-1:0] bytes_used;
   logic [FILL_W:0]    fill_after;
   logic [7:0]         xor_byte;
   logic [7:0]         rd_data;
   mem_req_type        mem_req;
   merge_in_type       merge_in;
   merge_out_type      merge_out;

   bvp_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   bvp_merge u_merge (
      .merge_in  (merge_in),
      .merge_out (merge_out)
   );

   assign fill_round = {1'b0, fill_ff} + (FILL_W+1)'(7);
   assign bytes_used = fill_round[BYTES_W+2:3];
   assign xor_byte   = rd_data ^ xor_ff;
   assign req_ready  = (state_ff == ST_IDLE) && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff      <= tail_in;
      data_ff      <= data_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      xor_ff       <= xor_in;
      res_data_ff  <= res_data_in;
      res_err_ff   <= res_err_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      tail_in      = tail_ff;
      data_in      = data_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      xor_in       = xor_ff;
      res_data_in  = res_data_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_bytes_in = rsp_bytes_ff;
      mem_req      = '0;
      fill_after   = '0;

      merge_in.off  = fill_ff[2:0];
      merge_in.rem  = rem_ff;
      merge_in.data = data_ff;
      merge_in.tail = tail_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in      = req_index;
               xor_in      = req_value[7:0];
               res_data_in = 8'd0;
               res_err_in  = ERR_NONE;
               state_in    = ST_FINISH;
               case (req_opcode)
                  OP_CLEAR: begin
                     fill_in = '0;
                  end
                  OP_APPEND_BIT: begin
                     fill_after = {1'b0, fill_ff} + (FILL_W+1)'(1);
                     if (req_value[31:1] != 31'd0) begin
                        res_err_in = ERR_BIT_VALUE;
                     end else if (fill_after > (FILL_W+1)'(CAP_BITS)) begin
                        res_err_in = ERR_OVERFLOW;
                     end else begin
                        data_in  = {req_value[0], 31'd0};
                        rem_in   = 6'd1;
                        state_in = ST_APPEND;
                     end
                  end
                  OP_APPEND_BITS: begin
                     fill_after = {1'b0, fill_ff} + (FILL_W+1)'(req_num_bits);
                     if (req_num_bits > MAX_APPEND_BITS) begin
                        res_err_in = ERR_BIT_COUNT;
                     end else if (fill_after > (FILL_W+1)'(CAP_BITS)) begin
                        res_err_in = ERR_OVERFLOW;
                     end else if (req_num_bits != 6'd0) begin
                        data_in  = req_value << (MAX_APPEND_BITS - req_num_bits);
                        rem_in   = req_num_bits;
                        state_in = ST_APPEND;
                     end
                  end
                  OP_READ_BIT: begin
                     if ({1'b0, req_index} >= fill_ff) begin
                        res_err_in = ERR_INDEX;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_index[ADDR_W+2:3];
                        state_in        = ST_READ_BIT;
                     end
                  end
                  OP_XOR_BYTE: begin
                     if (req_other_length != fill_ff) begin
                        res_err_in = ERR_LENGTH;
                     end else if (req_index >= 15'(bytes_used)) begin
                        res_err_in = ERR_INDEX;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_index[ADDR_W-1:0];
                        state_in        = ST_XOR;
                     end
                  end
                  OP_READ_BYTE: begin
                     if (req_index >= 15'(bytes_used)) begin
                        res_err_in = ERR_INDEX;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_index[ADDR_W-1:0];
                        state_in        = ST_READ_BYTE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_APPEND: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = fill_ff[ADDR_W+2:3];
            mem_req.wr_data = merge_out.wr_byte;
            tail_in         = merge_out.wr_byte;
            data_in         = merge_out.data;
            rem_in          = rem_ff - 6'(merge_out.take);
            fill_in         = fill_ff + FILL_W'(merge_out.take);
            if (rem_ff == 6'(merge_out.take)) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ_BIT: begin
            res_data_in = {7'd0, rd_data[3'd7 - idx_ff[2:0]]};
            state_in    = ST_FINISH;
         end
         ST_READ_BYTE: begin
            res_data_in = rd_data;
            state_in    = ST_FINISH;
         end
         ST_XOR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[ADDR_W-1:0];
            mem_req.wr_data = xor_byte;
            if (idx_ff[ADDR_W-1:0] == fill_ff[ADDR_W+2:3]) begin
               tail_in = xor_byte;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_err_in   = res_err_ff;
               rsp_bits_in  = fill_ff;
               rsp_bytes_in = bytes_used;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_error      = rsp_err_ff;
   assign rsp_bit_count  = rsp_bits_ff;
   assign rsp_byte_count = rsp_bytes_ff;

endmodule

// ===== sv/bvp_checker.sv =====
// Port-level checker for the MSB-first bit vector packer, with its bind.
// Depends only on the ports of msb_first_bit_vector_packer_unit.
module bvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_read_data,
   input logic [2:0]  rsp_error,
   input logic [15:0] rsp_bit_count,
   input logic [12:0] rsp_byte_count
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response word is valid right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_error) && $stable(rsp_bit_count) && $stable(rsp_byte_count))
      else $error("Stalled response word changed.");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((17'(rsp_bit_count) + 17'd7) >> 3) == 17'(rsp_byte_count))
      else $error("Byte count does not match bit count.");

   a_error_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != 3'd0 |-> rsp_read_data == 8'd0)
      else $error("Read data is nonzero on an error response.");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bit_count <= 16'd32768)
      else $error("Bit count exceeds the capacity.");

endmodule

bind msb_first_bit_vector_packer_unit bvp_checker u_bvp_checker (.*);

// ===== test/tb_msb_first_bit_vector_packer_unit.sv =====
// Self-checking testbench for msb_first_bit_vector_packer_unit.
// It predicts every response word from its own bit vector model and drives
// random valid/ready traffic on both sides. Needs bvp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_msb_first_bit_vector_packer_unit;
   import bvp_pkg::*;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [2:0]  error;
      logic [15:0] bit_count;
      logic [12:0] byte_count;
   } rsp_word_type;

   typedef struct {
      logic [2:0]  opcode;
      logic [31:0] value;
      logic [5:0]  num_bits;
      logic [14:0] index;
      logic [15:0] other_length;
      bit          drain_first;
      bit          hold_rsp;
   } req_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = '0;
   logic [31:0] req_value = '0;
   logic [5:0]  req_num_bits = '0;
   logic [14:0] req_index = '0;
   logic [15:0] req_other_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [2:0]  rsp_error;
   logic [15:0] rsp_bit_count;
   logic [12:0] rsp_byte_count;

   logic [7:0]  pack_store [CAP_BYTES];
   int unsigned pack_bits = 0;
   int unsigned plan_bits = 0;

   req_word_type pending_q [$];
   rsp_word_type rsp_expect_q [$];

   int          req_issued = 0;
   int          req_accepted = 0;
   int          rsp_taken = 0;
   int          rsp_seen = 0;
   int          hold_ask = 0;
   int          hold_seen = 0;
   int          fault_count = 0;
   int          drv_items = 0;
   int          gap_left = 0;
   int          rsp_wait_left = 0;
   int          hold_left = 0;

   msb_first_bit_vector_packer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .req_num_bits     (req_num_bits),
      .req_index        (req_index),
      .req_other_length (req_other_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_error        (rsp_error),
      .rsp_bit_count    (rsp_bit_count),
      .rsp_byte_count   (rsp_byte_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void put_bit(input logic b);
      if (pack_bits[2:0] == 3'd0) begin
         pack_store[pack_bits >> 3] = 8'h00;
      end
      pack_store[pack_bits >> 3] = pack_store[pack_bits >> 3]
                                   | ({7'b0, b} << (3'd7 - pack_bits[2:0]));
      pack_bits++;
   endfunction

   function automatic rsp_word_type pack_step(input logic [2:0] op, input logic [31:0] val,
                                              input logic [5:0] nb, input logic [14:0] idx,
                                              input logic [15:0] olen);
      rsp_word_type r;
      int unsigned  used;
      int           k;
      r = '0;
      used = (pack_bits + 7) >> 3;
      case (op)
         OP_CLEAR: begin
            pack_bits = 0;
         end
         OP_APPEND_BIT: begin
            if (val > 32'd1) r.error = ERR_BIT_VALUE;
            else if (pack_bits + 1 > CAP_BITS) r.error = ERR_OVERFLOW;
            else put_bit(val[0]);
         end
         OP_APPEND_BITS: begin
            if (nb > MAX_APPEND_BITS) r.error = ERR_BIT_COUNT;
            else if (pack_bits + nb > CAP_BITS) r.error = ERR_OVERFLOW;
            else for (k = nb; k > 0; k--) put_bit(val[k-1]);
         end
         OP_READ_BIT: begin
            if (idx >= pack_bits) r.error = ERR_INDEX;
            else r.read_data = {7'b0, pack_store[idx >> 3][3'd7 - idx[2:0]]};
         end
         OP_XOR_BYTE: begin
            if (olen != pack_bits) r.error = ERR_LENGTH;
            else if (idx >= used) r.error = ERR_INDEX;
            else pack_store[idx] = pack_store[idx] ^ val[7:0];
         end
         OP_READ_BYTE: begin
            if (idx >= used) r.error = ERR_INDEX;
            else r.read_data = pack_store[idx];
         end
         default: begin
         end
      endcase
      r.bit_count = 16'(pack_bits);
      r.byte_count = 13'((pack_bits + 7) >> 3);
      return r;
   endfunction

   function automatic int draw_wait(input int n);
      if ((n / 40) % 3 == 2) return 0;
      return $urandom_range(0, 17);
   endfunction

   task automatic add_word(input logic [2:0] op, input logic [31:0] val, input logic [5:0] nb,
                           input logic [14:0] idx, input logic [15:0] olen);
      req_word_type w;
      w.opcode = op;
      w.value = val;
      w.num_bits = nb;
      w.index = idx;
      w.other_length = olen;
      w.drain_first = 1'b0;
      w.hold_rsp = 1'b0;
      pending_q.push_back(w);
      case (op)
         OP_CLEAR: begin
            plan_bits = 0;
         end
         OP_APPEND_BIT: begin
            if (val <= 32'd1 && plan_bits + 1 <= CAP_BITS) plan_bits++;
         end
         OP_APPEND_BITS: begin
            if (nb <= MAX_APPEND_BITS && plan_bits + nb <= CAP_BITS) plan_bits += nb;
         end
         default: begin
         end
      endcase
   endtask

   task automatic add_noise_word();
      add_word(3'($urandom_range(0, 7)), $urandom, 6'($urandom_range(0, 63)),
               15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)));
   endtask

   task automatic add_sane_word();
      int unsigned used;
      logic [5:0]  nb;
      used = (plan_bits + 7) >> 3;
      case ($urandom_range(0, 9))
         0, 1: begin
            add_word(OP_APPEND_BIT, 32'($urandom_range(0, 1)), 6'($urandom),
                     15'($urandom), 16'($urandom));
         end
         2, 3, 4: begin
            nb = ($urandom_range(0, 7) == 0) ? 6'd32 : 6'($urandom_range(0, 32));
            add_word(OP_APPEND_BITS, $urandom, nb, 15'($urandom), 16'($urandom));
         end
         5, 6: begin
            add_word(OP_READ_BIT, $urandom, 6'($urandom),
                     15'(plan_bits != 0 ? $urandom_range(0, plan_bits - 1) : 0),
                     16'($urandom));
         end
         7: begin
            add_word(OP_XOR_BYTE, $urandom, 6'($urandom),
                     15'(used != 0 ? $urandom_range(0, used - 1) : 0), 16'(plan_bits));
         end
         default: begin
            add_word(OP_READ_BYTE, $urandom, 6'($urandom),
                     15'(used != 0 ? $urandom_range(0, used - 1) : 0), 16'($urandom));
         end
      endcase
   endtask

   always @(negedge clock) begin
      req_word_type w;
      logic         offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (offer && req_accepted == req_issued) begin
            offer = 1'b0;
            gap_left = draw_wait(drv_items);
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() != 0
                         && !(pending_q[0].drain_first && rsp_expect_q.size() != 0)) begin
               w = pending_q.pop_front();
               req_opcode <= w.opcode;
               req_value <= w.value;
               req_num_bits <= w.num_bits;
               req_index <= w.index;
               req_other_length <= w.other_length;
               if (w.hold_rsp) hold_ask <= hold_ask + 1;
               offer = 1'b1;
               req_issued++;
               drv_items++;
            end
         end
         req_valid <= offer;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_seen != rsp_taken) begin
            rsp_seen = rsp_taken;
            rsp_wait_left = draw_wait(rsp_taken);
         end else if (rsp_wait_left > 0) begin
            rsp_wait_left--;
         end
         if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = 300;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_ready <= (rsp_wait_left == 0 && hold_left == 0);
      end
   end

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            rsp_expect_q.push_back(pack_step(req_opcode, req_value, req_num_bits,
                                             req_index, req_other_length));
            req_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_read_data, rsp_error, rsp_bit_count, rsp_byte_count};
            rsp_taken++;
            if (rsp_expect_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: unexpected word: data %h err %0d bits %0d bytes %0d",
                           $realtime, got.read_data, got.error, got.bit_count,
                           got.byte_count);
            end else begin
               want = rsp_expect_q.pop_front();
               if (got.read_data !== want.read_data || got.error !== want.error
                   || got.bit_count !== want.bit_count
                   || got.byte_count !== want.byte_count) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"%0t: mismatch: want data %h err %0d bits %0d bytes %0d,",
                               " got data %h err %0d bits %0d bytes %0d"},
                              $realtime, want.read_data, want.error, want.bit_count,
                              want.byte_count, got.read_data, got.error, got.bit_count,
                              got.byte_count);
               end
            end
         end
      end
   end

   initial begin
      int  rand_start;
      bit  held;
      held = 1'b0;

      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd0, 16'd0);
      add_word(OP_READ_BIT, 32'd0, 6'd0, 15'd0, 16'd0);
      add_word(OP_XOR_BYTE, 32'hff, 6'd0, 15'd0, 16'd0);
      add_word(OP_XOR_BYTE, 32'hff, 6'd0, 15'd0, 16'h8000);
      add_word(OP_APPEND_BIT, 32'd2, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BIT, 32'hffff_ffff, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, 32'hffff_ffff, 6'd33, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, 32'hffff_ffff, 6'd63, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, 32'hffff_ffff, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BIT, 32'd1, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BIT, 32'd0, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, 32'hffff_ffff, 6'd32, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, 32'h0000_0000, 6'd32, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, 32'hffff_ffd5, 6'd5, 15'd0, 16'd0);
      add_word(OP_READ_BIT, 32'd0, 6'd0, 15'd0, 16'd0);
      add_word(OP_READ_BIT, 32'd0, 6'd0, 15'd70, 16'd0);
      add_word(OP_READ_BIT, 32'd0, 6'd0, 15'd71, 16'd0);
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd0, 16'd0);
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd8, 16'd0);
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd9, 16'd0);
      // The XOR of the partial last byte also flips the bits past the count.
      add_word(OP_XOR_BYTE, 32'hff, 6'd0, 15'd8, 16'd71);
      add_word(OP_APPEND_BITS, 32'd0, 6'd1, 15'd0, 16'd0);
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd8, 16'd0);
      add_word(3'd6, $urandom, 6'($urandom), 15'($urandom), 16'($urandom));
      add_word(3'd7, $urandom, 6'($urandom), 15'($urandom), 16'($urandom));
      add_word(OP_CLEAR, $urandom, 6'($urandom), 15'($urandom), 16'($urandom));
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd0, 16'd0);

      // Fill the store to capacity, then probe the overflow and the last entries.
      add_word(OP_CLEAR, 32'd0, 6'd0, 15'd0, 16'd0);
      pending_q[$].drain_first = 1'b1;
      repeat (1023) add_word(OP_APPEND_BITS, $urandom, 6'd32, 15'($urandom), 16'($urandom));
      add_word(OP_APPEND_BITS, $urandom, 6'd31, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, $urandom, 6'd2, 15'd0, 16'd0);
      add_word(OP_APPEND_BIT, 32'd1, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BIT, 32'd0, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, $urandom, 6'd0, 15'd0, 16'd0);
      add_word(OP_APPEND_BITS, $urandom, 6'd1, 15'd0, 16'd0);
      add_word(OP_READ_BIT, 32'd0, 6'd0, 15'h7fff, 16'd0);
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd4095, 16'd0);
      add_word(OP_XOR_BYTE, $urandom, 6'd0, 15'd4095, 16'h8000);
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd4095, 16'd0);
      add_word(OP_READ_BYTE, 32'd0, 6'd0, 15'd4096, 16'd0);
      add_word(OP_READ_BIT, 32'd0, 6'd0, 15'd0, 16'd0);
      add_word(OP_CLEAR, 32'd0, 6'd0, 15'd0, 16'd0);

      rand_start = pending_q.size();
      while (pending_q.size() < rand_start + 650) begin
         if (!held && pending_q.size() >= rand_start + 200) begin
            add_sane_word();
            pending_q[$].hold_rsp = 1'b1;
            held = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) == 0)
               add_word(OP_CLEAR, $urandom, 6'($urandom), 15'($urandom), 16'($urandom));
            repeat ($urandom_range(3, 12)) add_sane_word();
         end else begin
            repeat ($urandom_range(1, 4)) add_noise_word();
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fault_count == 0) begin
         $display("msb_first_bit_vector_packer_unit verification clean");
      end else begin
         $display("msb_first_bit_vector_packer_unit verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("msb_first_bit_vector_packer_unit verification failed");
      $finish;
   end

endmodule
